/* sv/x86e_pkg.sv */
package x86e_pkg;

    // Instruction kinds, numbered densely
    localparam logic [5:0] M_JMP_REL     = 6'd0;
    localparam logic [5:0] M_CALL_REL    = 6'd1;
    localparam logic [5:0] M_JMP_REG     = 6'd2;
    localparam logic [5:0] M_MOV_IMM32   = 6'd3;
    localparam logic [5:0] M_MOV_IMM64   = 6'd4;
    localparam logic [5:0] M_MOV_RR      = 6'd5;
    localparam logic [5:0] M_LOAD        = 6'd6;
    localparam logic [5:0] M_STORE       = 6'd7;
    localparam logic [5:0] M_RET         = 6'd8;
    localparam logic [5:0] M_PUSH        = 6'd9;
    localparam logic [5:0] M_POP         = 6'd10;
    localparam logic [5:0] M_ADD         = 6'd11;
    localparam logic [5:0] M_SUB         = 6'd12;
    localparam logic [5:0] M_AND         = 6'd13;
    localparam logic [5:0] M_XOR         = 6'd14;
    localparam logic [5:0] M_OR          = 6'd15;
    localparam logic [5:0] M_NOT         = 6'd16;
    localparam logic [5:0] M_TEST        = 6'd17;
    localparam logic [5:0] M_CMP         = 6'd18;
    localparam logic [5:0] M_IMUL_RR     = 6'd19;
    localparam logic [5:0] M_IMUL_RAX    = 6'd20;
    localparam logic [5:0] M_IDIV        = 6'd21;
    localparam logic [5:0] M_CALL_REG    = 6'd22;
    localparam logic [5:0] M_JE          = 6'd23;
    localparam logic [5:0] M_JNE         = 6'd24;
    localparam logic [5:0] M_JG          = 6'd25;
    localparam logic [5:0] M_JL          = 6'd26;
    localparam logic [5:0] M_JGE         = 6'd27;
    localparam logic [5:0] M_JLE         = 6'd28;
    localparam logic [5:0] M_JA          = 6'd29;
    localparam logic [5:0] M_JB          = 6'd30;
    localparam logic [5:0] M_JAE         = 6'd31;
    localparam logic [5:0] M_JBE         = 6'd32;
    localparam logic [5:0] M_MOVQ_G_X    = 6'd33;
    localparam logic [5:0] M_MOVQ_X_G    = 6'd34;
    localparam logic [5:0] M_MOVQ_X_X    = 6'd35;
    localparam logic [5:0] M_MOVQ_X_M    = 6'd36;
    localparam logic [5:0] M_MOVQ_M_X    = 6'd37;
    localparam logic [5:0] M_ADDSD       = 6'd38;
    localparam logic [5:0] M_SUBSD       = 6'd39;
    localparam logic [5:0] M_MULSD       = 6'd40;
    localparam logic [5:0] M_DIVSD       = 6'd41;
    localparam logic [5:0] M_PXOR        = 6'd42;
    localparam logic [5:0] M_COMISD      = 6'd43;
    localparam logic [5:0] M_CVTTSD2SI   = 6'd44;
    localparam logic [5:0] M_CVTSI2SD    = 6'd45;

    localparam int MAX_BYTES = 10;

    // Fixed prefix and opcode bytes
    localparam logic [7:0] B_REX_B   = 8'h41;
    localparam logic [7:0] B_REX_W   = 8'h48;
    localparam logic [7:0] B_REX_WB  = 8'h49;
    localparam logic [7:0] B_JMP     = 8'he9;
    localparam logic [7:0] B_CALL    = 8'he8;
    localparam logic [7:0] B_ESC     = 8'h0f;
    localparam logic [7:0] B_PFX_F2  = 8'hf2;
    localparam logic [7:0] B_PFX_66  = 8'h66;
    localparam logic [7:0] B_PFX_F3  = 8'hf3;
    localparam logic [1:0] MOD_REG   = 2'b11;
    localparam logic [1:0] MOD_MEM   = 2'b00;
    localparam logic [7:0] B_MOV_IMM = 8'hb8;
    localparam logic [7:0] B_RET     = 8'hc3;

    typedef logic [MAX_BYTES-1:0][7:0] t_bytes;

    // Encoded instruction passed from encoder to serializer
    typedef struct packed {
        t_bytes     bytes;
        logic [3:0] count;
    } t_enc_instr;

    // Low three bits of the hardware register number
    function automatic logic [2:0] lo3(input logic [4:0] r);
        logic [2:0] v;
        case (r)
            5'd0:    v = 3'd0;
            5'd1:    v = 3'd3;
            5'd2:    v = 3'd1;
            5'd3:    v = 3'd2;
            5'd4:    v = 3'd7;
            5'd5:    v = 3'd6;
            5'd6, 5'd14:  v = 3'd0;
            5'd7, 5'd15:  v = 3'd1;
            5'd8, 5'd16:  v = 3'd2;
            5'd9, 5'd17:  v = 3'd3;
            5'd10, 5'd18: v = 3'd4;
            5'd11, 5'd19: v = 3'd5;
            5'd12, 5'd20: v = 3'd6;
            5'd13, 5'd21: v = 3'd7;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // Any code from r8 upward sets the REX extension bit
    function automatic logic ext(input logic [4:0] r);
        return (r >= 5'd6);
    endfunction

    function automatic logic [7:0] rex_w(input logic [4:0] reg_op, input logic [4:0] rm_op);
        return B_REX_W | {5'b0, ext(reg_op), 1'b0, ext(rm_op)};
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [4:0] reg_op,
                                         input logic [4:0] rm_op);
        return {md, lo3(reg_op), lo3(rm_op)};
    endfunction

    // Register-register ALU opcode
    function automatic logic [7:0] alu_op(input logic [5:0] m);
        logic [7:0] v;
        case (m)
            M_ADD:   v = 8'h01;
            M_SUB:   v = 8'h29;
            M_AND:   v = 8'h21;
            M_XOR:   v = 8'h31;
            M_OR:    v = 8'h09;
            M_TEST:  v = 8'h85;
            M_CMP:   v = 8'h39;
            default: v = 8'h89;
        endcase
        return v;
    endfunction

    // Second opcode byte of the conditional jumps
    function automatic logic [7:0] jcc_op(input logic [5:0] m);
        logic [7:0] v;
        case (m)
            M_JE:    v = 8'h84;
            M_JNE:   v = 8'h85;
            M_JG:    v = 8'h8f;
            M_JL:    v = 8'h8c;
            M_JGE:   v = 8'h8d;
            M_JLE:   v = 8'h8e;
            M_JA:    v = 8'h87;
            M_JB:    v = 8'h82;
            M_JAE:   v = 8'h83;
            default: v = 8'h86;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] sd_op(input logic [5:0] m);
        logic [7:0] v;
        case (m)
            M_ADDSD: v = 8'h58;
            M_SUBSD: v = 8'h5c;
            M_MULSD: v = 8'h59;
            default: v = 8'h5e;
        endcase
        return v;
    endfunction

endpackage

/* sv/x86e_encode.sv */
module x86e_encode
    import x86e_pkg::*;
(
    input  logic [5:0]        i_mode,
    input  logic [4:0]        i_first_reg,
    input  logic [4:0]        i_second_reg,
    input  logic signed [63:0] i_immediate,
    output t_enc_instr        o_instr
);

    logic [4:0] a;
    logic [4:0] s;
    logic [2:0] lo_a;
    logic       ea;
    logic       es;
    t_bytes     body;
    logic [3:0] body_cnt;
    logic       pfx_en;

    assign a    = i_first_reg;
    assign s    = i_second_reg;
    assign lo_a = lo3(a);
    assign ea   = ext(a);
    assign es   = ext(s);

    // Build the instruction body; an optional REX.B prefix is prepended below
    always_comb begin
        body     = '0;
        body_cnt = 4'd0;
        pfx_en   = 1'b0;
        unique case (i_mode) inside
            M_JMP_REL, M_CALL_REL: begin
                body[0]  = (i_mode == M_JMP_REL) ? B_JMP : B_CALL;
                body[1]  = i_immediate[7:0];
                body[2]  = i_immediate[15:8];
                body[3]  = i_immediate[23:16];
                body[4]  = i_immediate[31:24];
                body_cnt = 4'd5;
            end
            M_JMP_REG, M_CALL_REG: begin
                pfx_en   = ea;
                body[0]  = 8'hff;
                body[1]  = ((i_mode == M_JMP_REG) ? 8'he0 : 8'hd0) | {5'b0, lo_a};
                body_cnt = 4'd2;
            end
            M_MOV_IMM32: begin
                pfx_en   = ea;
                body[0]  = B_MOV_IMM | {5'b0, lo_a};
                body[1]  = i_immediate[7:0];
                body[2]  = i_immediate[15:8];
                body[3]  = i_immediate[23:16];
                body[4]  = i_immediate[31:24];
                body_cnt = 4'd5;
            end
            M_MOV_IMM64: begin
                body[0]  = ea ? B_REX_WB : B_REX_W;
                body[1]  = B_MOV_IMM | {5'b0, lo_a};
                body[2]  = i_immediate[7:0];
                body[3]  = i_immediate[15:8];
                body[4]  = i_immediate[23:16];
                body[5]  = i_immediate[31:24];
                body[6]  = i_immediate[39:32];
                body[7]  = i_immediate[47:40];
                body[8]  = i_immediate[55:48];
                body[9]  = i_immediate[63:56];
                body_cnt = 4'd10;
            end
            M_MOV_RR, M_ADD, M_SUB, M_AND, M_XOR, M_OR, M_TEST, M_CMP: begin
                body[0]  = rex_w(s, a);
                body[1]  = alu_op(i_mode);
                body[2]  = modrm(MOD_REG, s, a);
                body_cnt = 4'd3;
            end
            M_LOAD: begin
                body[0]  = rex_w(a, s);
                body[1]  = 8'h8b;
                body[2]  = modrm(MOD_MEM, a, s);
                body_cnt = 4'd3;
            end
            M_STORE: begin
                body[0]  = rex_w(s, a);
                body[1]  = 8'h89;
                body[2]  = modrm(MOD_MEM, s, a);
                body_cnt = 4'd3;
            end
            M_RET: begin
                body[0]  = B_RET;
                body_cnt = 4'd1;
            end
            M_PUSH, M_POP: begin
                pfx_en   = ea;
                body[0]  = ((i_mode == M_PUSH) ? 8'h50 : 8'h58) | {5'b0, lo_a};
                body_cnt = 4'd1;
            end
            M_NOT, M_IMUL_RAX, M_IDIV: begin
                body[0]  = B_REX_W | {7'b0, ea};
                body[1]  = 8'hf7;
                body[2]  = ((i_mode == M_NOT) ? 8'hd0 :
                            (i_mode == M_IMUL_RAX) ? 8'he8 : 8'hf8) | {5'b0, lo_a};
                body_cnt = 4'd3;
            end
            M_IMUL_RR: begin
                body[0]  = rex_w(a, s);
                body[1]  = B_ESC;
                body[2]  = 8'haf;
                body[3]  = modrm(MOD_REG, a, s);
                body_cnt = 4'd4;
            end
            [M_JE:M_JBE]: begin
                body[0]  = B_ESC;
                body[1]  = jcc_op(i_mode);
                body[2]  = i_immediate[7:0];
                body[3]  = i_immediate[15:8];
                body[4]  = i_immediate[23:16];
                body[5]  = i_immediate[31:24];
                body_cnt = 4'd6;
            end
            M_MOVQ_G_X: begin
                body[0]  = B_PFX_66;
                body[1]  = B_REX_W | {7'b0, ea};
                body[2]  = B_ESC;
                body[3]  = 8'h7e;
                body[4]  = modrm(MOD_REG, s, a);
                body_cnt = 4'd5;
            end
            M_MOVQ_X_G: begin
                body[0]  = B_PFX_66;
                body[1]  = B_REX_W | {7'b0, es};
                body[2]  = B_ESC;
                body[3]  = 8'h6e;
                body[4]  = modrm(MOD_REG, a, s);
                body_cnt = 4'd5;
            end
            M_MOVQ_X_X, M_MOVQ_X_M: begin
                body[0]  = B_PFX_F3;
                body[1]  = B_ESC;
                body[2]  = 8'h7e;
                body[3]  = modrm((i_mode == M_MOVQ_X_X) ? MOD_REG : MOD_MEM, a, s);
                body_cnt = 4'd4;
            end
            M_MOVQ_M_X: begin
                body[0]  = B_PFX_66;
                body[1]  = B_ESC;
                body[2]  = 8'hd6;
                body[3]  = modrm(MOD_MEM, s, a);
                body_cnt = 4'd4;
            end
            [M_ADDSD:M_DIVSD]: begin
                body[0]  = B_PFX_F2;
                body[1]  = B_ESC;
                body[2]  = sd_op(i_mode);
                body[3]  = modrm(MOD_REG, a, s);
                body_cnt = 4'd4;
            end
            M_PXOR, M_COMISD: begin
                body[0]  = B_PFX_66;
                body[1]  = B_ESC;
                body[2]  = (i_mode == M_PXOR) ? 8'hef : 8'h2f;
                body[3]  = modrm(MOD_REG, a, s);
                body_cnt = 4'd4;
            end
            M_CVTTSD2SI: begin
                body[0]  = B_PFX_F2;
                body[1]  = B_REX_W | {5'b0, ea, 2'b0};
                body[2]  = B_ESC;
                body[3]  = 8'h2c;
                body[4]  = modrm(MOD_REG, a, s);
                body_cnt = 4'd5;
            end
            M_CVTSI2SD: begin
                body[0]  = B_PFX_F2;
                body[1]  = B_REX_W | {7'b0, es};
                body[2]  = B_ESC;
                body[3]  = 8'h2a;
                body[4]  = modrm(MOD_REG, a, s);
                body_cnt = 4'd5;
            end
            default: begin
                body_cnt = 4'd0;
            end
        endcase
    end

    // Prepend REX.B where the single register operand is extended
    always_comb begin
        if (pfx_en) begin
            o_instr.bytes = {body[MAX_BYTES-2:0], B_REX_B};
            o_instr.count = body_cnt + 4'd1;
        end else begin
            o_instr.bytes = body;
            o_instr.count = body_cnt;
        end
    end

endmodule

/* sv/x86e_serializer.sv */
module x86e_serializer
    import x86e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_enc_instr i_instr,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_free
);

    logic       r_valid;
    logic [3:0] r_idx;
    logic [3:0] r_cnt;
    t_bytes     r_buf;
    logic       n_valid;
    logic [3:0] n_idx;

    assign o_valid = r_valid;
    assign o_byte  = r_buf[r_idx];
    assign o_last  = (r_idx == r_cnt - 4'd1);
    // Free when empty or when the final byte leaves this cycle
    assign o_free  = !r_valid || (i_ready && o_last);

    // Advance through the buffered bytes; reload on a new instruction
    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = (i_instr.count != 4'd0);
            n_idx   = 4'd0;
        end else if (r_valid && i_ready) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_instr.bytes;
            r_cnt <= i_instr.count;
        end
    end

endmodule

/* sv/x86_64_instruction_encoder_unit.sv */
// x86-64 instruction encoder.
// Input channel (i_in_valid / o_in_ready) takes one instruction request per
// transaction: kind, two register codes and a 64-bit immediate.
// Output channel (o_out_valid / i_out_ready) returns the machine code one byte
// per transaction, with o_last_byte high on the final byte.
// A request is first captured in the input register, encoded by one pass of
// combinational logic and loaded into the byte buffer once the buffer is
// free, and the first byte is offered right after that load.
// The buffer sends one byte per cycle while the receiver is ready. An
// instruction holds 1 to 10 bytes (three to five typical); the input register
// can take the next request while the buffer is sending, and the next request
// is loaded in the same cycle that the last byte of the previous one is taken.
// Unknown kinds produce no bytes and leave the byte buffer empty.
// When the receiver stalls the current byte holds and the input register
// fills, after which o_in_ready drops.
// Reset (i_rst_n low, synchronous) empties the input register and the byte
// buffer; no state is kept between instructions.
module x86_64_instruction_encoder_unit
    import x86e_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [5:0]         i_mode,
    input  logic [4:0]         i_first_reg,
    input  logic [4:0]         i_second_reg,
    input  logic signed [63:0] i_immediate,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_code_byte,
    output logic               o_last_byte
);

    logic               r_in_valid;
    logic               n_in_valid;
    logic [5:0]         r_mode;
    logic [4:0]         r_first_reg;
    logic [4:0]         r_second_reg;
    logic signed [63:0] r_immediate;
    t_enc_instr         enc;
    logic               buf_free;
    logic               load;
    logic               in_take;

    assign load       = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || buf_free;
    assign in_take    = i_in_valid && o_in_ready;

    // Input register: fill on a transaction, drain into the byte buffer
    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode       <= i_mode;
            r_first_reg  <= i_first_reg;
            r_second_reg <= i_second_reg;
            r_immediate  <= i_immediate;
        end
    end

    x86e_encode u_encode (
        .i_mode       (r_mode),
        .i_first_reg  (r_first_reg),
        .i_second_reg (r_second_reg),
        .i_immediate  (r_immediate),
        .o_instr      (enc)
    );

    x86e_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_instr (enc),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_byte  (o_code_byte),
        .o_last  (o_last_byte),
        .o_free  (buf_free)
    );

    // A non-final byte taken always leaves another byte pending
    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_byte) |=> o_out_valid)
        else $error("byte stream broke before last byte");

    // Final byte taken with nothing loaded empties the output
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_byte && !load) |=> !o_out_valid)
        else $error("output stayed valid after final byte");

    // A load never overwrites an instruction still being sent
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!o_out_valid || (i_out_ready && o_last_byte)))
        else $error("byte buffer overwritten mid-instruction");

    // An accepted request is held in the input register
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted request lost");

endmodule
